// File: rtl/rdst_pkg.sv
// Shared constants, types and address helpers for the dedup slot table.
// No dependencies; used by rdst_scan and the top level.
`default_nettype none

package rdst_pkg;

    localparam int TABLES     = 3;
    localparam int SPRITES    = 1024;
    localparam int SLOTS      = 255;
    localparam int KEY_WIDTH  = 64;

    localparam int FUNC_W     = 1;
    localparam int KIND_W     = 2;
    localparam int SPR_W      = 10;
    localparam int KEY_IN_W   = 64;
    localparam int SLOT_OUT_W = 8;

    localparam int SLOT_W     = $clog2(SLOTS + 1);
    localparam int CNT_W      = $clog2(SPRITES + 1);
    localparam int EA_W       = $clog2(TABLES * SLOTS);
    localparam int SA_W       = $clog2(TABLES * SPRITES);

    localparam logic [FUNC_W-1:0] FUNC_SET = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_REL = 1'b1;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [SPR_W-1:0]     t_spr;
    typedef logic [EA_W-1:0]      t_eaddr;
    typedef logic [SA_W-1:0]      t_saddr;

    typedef struct packed {
        logic  key_eq;
        logic  m_found;
        t_slot m_idx;
        t_cnt  m_cnt;
        logic  f_found;
        t_slot f_idx;
    } t_scan;

    function automatic t_eaddr ent_addr(input t_kind t, input t_slot idx);
        return EA_W'(32'(t) * SLOTS + 32'(idx));
    endfunction

    function automatic t_saddr spr_addr(input t_kind t, input t_spr spr);
        return SA_W'(32'(t) * SPRITES + 32'(spr));
    endfunction

endpackage

`default_nettype wire

// File: rtl/rdst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rdst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/rdst_scan.sv
// Shared key compare and first-match / first-free tracker for the slot scan.
// Depends on rdst_pkg.
`default_nettype none

module rdst_scan (
    input  wire logic           i_clk,
    input  wire logic           i_clear,
    input  wire logic           i_issue,
    input  wire rdst_pkg::t_slot i_idx,
    input  wire rdst_pkg::t_key  i_key,
    input  wire rdst_pkg::t_key  i_key_rd,
    input  wire rdst_pkg::t_cnt  i_cnt_rd,
    output rdst_pkg::t_scan      o_info
);
    import rdst_pkg::*;

    logic  r_pend;
    t_slot r_pidx;
    logic  r_mfound;
    t_slot r_midx;
    t_cnt  r_mcnt;
    logic  r_ffound;
    t_slot r_fidx;
    logic  key_eq;
    logic  live;

    assign key_eq = (i_key_rd == i_key);
    assign live   = (i_cnt_rd != '0);

    always_ff @(posedge i_clk) begin
        r_pidx <= i_idx;
        if (i_clear) begin
            r_pend   <= 1'b0;
            r_mfound <= 1'b0;
            r_ffound <= 1'b0;
        end else begin
            r_pend <= i_issue;
            if (r_pend && live && key_eq && !r_mfound) begin
                r_mfound <= 1'b1;
                r_midx   <= r_pidx;
                r_mcnt   <= i_cnt_rd;
            end
            if (r_pend && !live && !r_ffound) begin
                r_ffound <= 1'b1;
                r_fidx   <= r_pidx;
            end
        end
    end

    always_comb begin
        o_info.key_eq  = key_eq;
        o_info.m_found = r_mfound;
        o_info.m_idx   = r_midx;
        o_info.m_cnt   = r_mcnt;
        o_info.f_found = r_ffound;
        o_info.f_idx   = r_fidx;
    end

endmodule

`default_nettype wire

// File: rtl/refcounted_dedup_slot_table_unit.sv
// Top level: sequencer, key/count/sprite-slot RAMs and the shared scan unit.
// Depends on rdst_pkg, rdst_ram and rdst_scan.
//
// Usage: after reset the block runs a clearing pass over max(3*SPRITES,
// 3*SLOTS) RAM addresses (3072 here) with busy high. A request is taken when
// start is high and busy is low. A set request that needs a table lookup
// walks all SLOTS entries of its table through one compare unit, one entry
// per cycle on the key/count RAM read port, then S_SCAN_END and S_FIN before
// the result strobe o_valid. Same-key sets, removals and rejected requests
// need no scan; a release visits the sprite in each table in turn. The result
// is presented for exactly one cycle with o_valid and cannot be held off;
// busy drops the cycle after it.
`default_nettype none

module refcounted_dedup_slot_table_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [rdst_pkg::FUNC_W-1:0]       i_func,
    input  wire logic [rdst_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [rdst_pkg::SPR_W-1:0]        i_sprite,
    input  wire logic [rdst_pkg::KEY_IN_W-1:0]     i_key,
    output logic                                   o_valid,
    output logic [rdst_pkg::SLOT_OUT_W-1:0]        o_slot,
    output logic                                   o_sprite_changed,
    output logic                                   o_new_entry,
    output logic                                   o_status
);
    import rdst_pkg::*;

    localparam int CLR_N = (TABLES * SPRITES > TABLES * SLOTS) ?
                           TABLES * SPRITES : TABLES * SLOTS;
    localparam int CLR_W = $clog2(CLR_N);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_SPR_RD   = 9'b000000100,
        S_OLD      = 9'b000001000,
        S_ENT      = 9'b000010000,
        S_SCAN     = 9'b000100000,
        S_SCAN_END = 9'b001000000,
        S_FIN      = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    logic [CLR_W-1:0] r_clr, n_clr;
    logic             r_rel, n_rel;
    t_kind            r_t, n_t;
    t_spr             r_spr, n_spr;
    t_key             r_key, n_key;
    t_slot            r_old, n_old;
    t_slot            r_idx, n_idx;
    t_slot            r_slot, n_slot;
    logic             r_chg, n_chg;
    logic             r_new, n_new;
    logic             r_stat, n_stat;

    logic   spr_we;
    t_saddr spr_waddr, spr_raddr;
    t_slot  spr_wdata, spr_rdata;
    logic   cnt_we;
    t_eaddr cnt_waddr, ent_raddr;
    t_cnt   cnt_wdata, cnt_rdata;
    logic   key_we;
    t_eaddr key_waddr;
    t_key   key_rdata;
    t_scan  scan;

    rdst_ram #(.WIDTH(SLOT_W), .DEPTH(TABLES * SPRITES)) u_spr_ram (
        .i_clk   (i_clk),
        .i_we    (spr_we),
        .i_waddr (spr_waddr),
        .i_wdata (spr_wdata),
        .i_raddr (spr_raddr),
        .o_rdata (spr_rdata)
    );

    rdst_ram #(.WIDTH(CNT_W), .DEPTH(TABLES * SLOTS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (cnt_rdata)
    );

    rdst_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLES * SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_raddr (ent_raddr),
        .o_rdata (key_rdata)
    );

    rdst_scan u_scan (
        .i_clk    (i_clk),
        .i_clear  (r_state == S_IDLE),
        .i_issue  (r_state == S_SCAN),
        .i_idx    (r_idx),
        .i_key    (r_key),
        .i_key_rd (key_rdata),
        .i_cnt_rd (cnt_rdata),
        .o_info   (scan)
    );

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = (r_state == S_DONE);
    assign o_slot           = SLOT_OUT_W'(r_slot);
    assign o_sprite_changed = r_chg;
    assign o_new_entry      = r_new;
    assign o_status         = r_stat;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_rel   = r_rel;
        n_t     = r_t;
        n_spr   = r_spr;
        n_key   = r_key;
        n_old   = r_old;
        n_idx   = r_idx;
        n_slot  = r_slot;
        n_chg   = r_chg;
        n_new   = r_new;
        n_stat  = r_stat;

        spr_raddr = spr_addr(r_t, r_spr);
        ent_raddr = ent_addr(r_t, r_idx);
        spr_we    = 1'b0;
        spr_waddr = spr_addr(r_t, r_spr);
        spr_wdata = '0;
        cnt_we    = 1'b0;
        cnt_waddr = ent_addr(r_t, r_old - t_slot'(1));
        cnt_wdata = cnt_rdata - t_cnt'(1);
        key_we    = 1'b0;
        key_waddr = ent_addr(r_t, scan.f_idx);

        unique case (r_state)
            S_CLEAR: begin
                spr_we    = (32'(r_clr) < TABLES * SPRITES);
                spr_waddr = SA_W'(r_clr);
                cnt_we    = (32'(r_clr) < TABLES * SLOTS);
                cnt_waddr = EA_W'(r_clr);
                cnt_wdata = '0;
                n_clr     = r_clr + CLR_W'(1);
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_rel  = (i_func == FUNC_REL);
                    n_t    = (i_func == FUNC_REL) ? t_kind'(0) : i_kind;
                    n_spr  = i_sprite;
                    n_key  = i_key[KEY_WIDTH-1:0];
                    n_slot = '0;
                    n_chg  = 1'b0;
                    n_new  = 1'b0;
                    n_stat = 1'b0;
                    if (32'(i_sprite) >= SPRITES ||
                        (i_func == FUNC_SET && 32'(i_kind) >= TABLES)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SPR_RD;
                    end
                end
            end
            S_SPR_RD: begin
                n_state = S_OLD;
            end
            S_OLD: begin
                n_old     = spr_rdata;
                ent_raddr = ent_addr(r_t, spr_rdata - t_slot'(1));
                n_idx     = '0;
                if (spr_rdata != '0) begin
                    n_state = S_ENT;
                end else if (r_rel) begin
                    if (r_t == t_kind'(TABLES - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_t     = r_t + t_kind'(1);
                        n_state = S_SPR_RD;
                    end
                end else if (r_key == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_ENT: begin
                n_idx = '0;
                if (r_rel || r_key == '0) begin
                    cnt_we = (cnt_rdata != '0);
                    spr_we = 1'b1;
                    n_chg  = 1'b1;
                    if (r_rel && r_t != t_kind'(TABLES - 1)) begin
                        n_t     = r_t + t_kind'(1);
                        n_state = S_SPR_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (scan.key_eq) begin
                    n_slot  = r_old;
                    n_state = S_DONE;
                end else begin
                    cnt_we  = (cnt_rdata != '0);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == t_slot'(SLOTS - 1)) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_idx = r_idx + t_slot'(1);
                end
            end
            S_SCAN_END: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                spr_we  = 1'b1;
                n_state = S_DONE;
                if (scan.m_found) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = ent_addr(r_t, scan.m_idx);
                    cnt_wdata = scan.m_cnt + t_cnt'(1);
                    spr_wdata = scan.m_idx + t_slot'(1);
                    n_slot    = scan.m_idx + t_slot'(1);
                    n_chg     = 1'b1;
                end else if (scan.f_found) begin
                    key_we    = 1'b1;
                    cnt_we    = 1'b1;
                    cnt_waddr = ent_addr(r_t, scan.f_idx);
                    cnt_wdata = t_cnt'(1);
                    spr_wdata = scan.f_idx + t_slot'(1);
                    n_slot    = scan.f_idx + t_slot'(1);
                    n_new     = 1'b1;
                    n_chg     = 1'b1;
                end else begin
                    n_slot = '0;
                    n_stat = 1'b1;
                    n_chg  = (r_old != '0);
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rel  <= n_rel;
        r_t    <= n_t;
        r_spr  <= n_spr;
        r_key  <= n_key;
        r_old  <= n_old;
        r_idx  <= n_idx;
        r_slot <= n_slot;
        r_chg  <= n_chg;
        r_new  <= n_new;
        r_stat <= n_stat;
    end

endmodule

`default_nettype wire
